### design/bfr_pkg.sv
// ----------------------------------------------------------------------------
// Best-fit region finder package
// Shared widths, register indexes and the word and configuration structs.
// ----------------------------------------------------------------------------
package bfr_pkg;

    localparam int ADDR_W         = 64;
    localparam int KIND_W         = 32;
    localparam int CFG_IDX_W      = 3;
    localparam int EXCL_CNT_W     = 2;
    // Ranges held in registers, and how many of them the search may use.
    localparam int EXCL_REGS      = 2;
    localparam int MAX_EXCLUSIONS = 2;

    localparam logic [KIND_W-1:0] KIND_USABLE_RAM = KIND_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REQUEST_SIZE = 3'd0,
        REG_EXCL_COUNT   = 3'd1,
        REG_EXCL0_START  = 3'd2,
        REG_EXCL0_END    = 3'd3,
        REG_EXCL1_START  = 3'd4,
        REG_EXCL1_END    = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [ADDR_W-1:0]                   request_size;
        logic [EXCL_CNT_W-1:0]               excl_count;
        logic [EXCL_REGS-1:0][ADDR_W-1:0]    excl_start;
        logic [EXCL_REGS-1:0][ADDR_W-1:0]    excl_end;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] size;
        logic [KIND_W-1:0] kind;
        logic              last;
    } entry_t;

endpackage

### design/bfr_cfg_regs.sv
// ----------------------------------------------------------------------------
// Best-fit region finder configuration registers
// Decodes the write port into the request size and the exclusion ranges.
// ----------------------------------------------------------------------------
module bfr_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [bfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bfr_pkg::ADDR_W-1:0]    cfg_wr_data,
    output bfr_pkg::cfg_t                 cfg
);
    import bfr_pkg::*;

    cfg_t cfg_reg;

    // Indexes outside the register list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_REQUEST_SIZE: cfg_reg.request_size  <= cfg_wr_data;
                REG_EXCL_COUNT:   cfg_reg.excl_count    <= cfg_wr_data[EXCL_CNT_W-1:0];
                REG_EXCL0_START:  cfg_reg.excl_start[0] <= cfg_wr_data;
                REG_EXCL0_END:    cfg_reg.excl_end[0]   <= cfg_wr_data;
                REG_EXCL1_START:  cfg_reg.excl_start[1] <= cfg_wr_data;
                REG_EXCL1_END:    cfg_reg.excl_end[1]   <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### design/bfr_entry_check.sv
// ----------------------------------------------------------------------------
// Best-fit region finder entry check
// Decides whether one map entry is usable: right kind, large enough, and
// clear of every active exclusion range.
// ----------------------------------------------------------------------------
module bfr_entry_check (
    input  bfr_pkg::cfg_t   cfg,
    input  bfr_pkg::entry_t entry,
    output logic            usable
);
    import bfr_pkg::*;

    logic [ADDR_W:0] entry_end;
    logic            excluded;

    // The entry end is kept one bit wider so that it never wraps. Ranges
    // are half-open, yet empty or inverted ranges can still exclude entries.
    always_comb begin
        entry_end = {1'b0, entry.base} + {1'b0, entry.size};
        excluded  = 1'b0;
        for (int i = 0; i < EXCL_REGS; i++) begin
            if ((i < MAX_EXCLUSIONS) && (cfg.excl_count > EXCL_CNT_W'(i)) &&
                (entry.base < cfg.excl_end[i]) &&
                ({1'b0, cfg.excl_start[i]} < entry_end)) begin
                excluded = 1'b1;
            end
        end
        usable = !excluded && (entry.kind == KIND_USABLE_RAM) &&
                 (entry.size >= cfg.request_size);
    end

endmodule

### design/bfr_best_track.sv
// ----------------------------------------------------------------------------
// Best-fit region finder best tracker
// Holds the running smallest usable entry and the result register.
// ----------------------------------------------------------------------------
module bfr_best_track (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       advance,
    input  bfr_pkg::entry_t            entry,
    input  logic                       usable,
    input  logic                       m_ready,
    output logic                       out_free,
    output logic                       m_valid,
    output logic                       m_found,
    output logic [bfr_pkg::ADDR_W-1:0] m_chosen_base
);
    import bfr_pkg::*;

    logic              have_best_reg, have_best_next;
    logic [ADDR_W-1:0] best_size_reg, best_size_next;
    logic [ADDR_W-1:0] best_base_reg, best_base_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_found_reg;
    logic [ADDR_W-1:0] m_base_reg;

    logic              take;
    logic              merged_have;
    logic [ADDR_W-1:0] merged_size;
    logic [ADDR_W-1:0] merged_base;
    logic              emit;

    always_comb begin
        // Strictly smaller only, so ties keep the earlier entry.
        take        = usable && (!have_best_reg || (entry.size < best_size_reg));
        merged_have = have_best_reg || take;
        merged_size = take ? entry.size : best_size_reg;
        merged_base = take ? entry.base : best_base_reg;
        emit        = advance && entry.last;

        have_best_next = have_best_reg;
        best_size_next = best_size_reg;
        best_base_next = best_base_reg;
        if (advance) begin
            have_best_next = merged_have && !entry.last;
            best_size_next = merged_size;
            best_base_next = merged_base;
        end

        out_free     = !m_valid_reg || m_ready;
        m_valid_next = emit || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_best_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            have_best_reg <= have_best_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        best_size_reg <= best_size_next;
        best_base_reg <= best_base_next;
        if (emit) begin
            m_found_reg <= merged_have;
            m_base_reg  <= merged_have ? merged_base : '0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_chosen_base = m_base_reg;

endmodule

### design/best_fit_region_finder.sv
// ----------------------------------------------------------------------------
// Best-fit region finder
// Streams memory-map entries and reports the smallest usable region per map.
// ----------------------------------------------------------------------------
// Each word on the s_ channel is one memory-map entry: base, size, type code
// and a last-entry mark. The block keeps the smallest entry of type 1 that is
// at least the requested size and overlaps none of the active exclusion
// ranges; ties keep the earlier entry. Only the word marked last produces a
// result word on the m_ channel: a found flag and the chosen base, or zero.
// The running best is then cleared for the next map.
// An entry is taken into an input register, checked and merged with the
// running best from there, and the result word is written into the output
// register. One entry can be accepted every cycle, set by the single
// compare-and-select stage between the input and output registers, except
// while a last entry waits for the result register to free up.
// When the receiver stalls, the held result stays put and non-last entries
// keep flowing; only a further last entry waits in the input register.
// Reset (aresetn low, synchronous) clears the configuration registers, the
// running best and both valid flags. The user must write configuration only
// while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module best_fit_region_finder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [bfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bfr_pkg::ADDR_W-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bfr_pkg::ADDR_W-1:0]    s_entry_base,
    input  logic [bfr_pkg::ADDR_W-1:0]    s_entry_size,
    input  logic [bfr_pkg::KIND_W-1:0]    s_entry_kind,
    input  logic                          s_entry_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_found,
    output logic [bfr_pkg::ADDR_W-1:0]    m_chosen_base
);
    import bfr_pkg::*;

    cfg_t   cfg;
    entry_t entry_reg;
    logic   entry_valid_reg;
    logic   usable;
    logic   out_free;
    logic   advance;
    logic   accept;

    bfr_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // A non-last entry always moves on; a last one needs the result register
    // to be empty or emptying in this cycle.
    assign advance = entry_valid_reg && (!entry_reg.last || out_free);
    assign s_ready = !entry_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= 1'b0;
        end else if (s_ready) begin
            entry_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            entry_reg.base <= s_entry_base;
            entry_reg.size <= s_entry_size;
            entry_reg.kind <= s_entry_kind;
            entry_reg.last <= s_entry_last;
        end
    end

    bfr_entry_check u_check (
        .cfg    (cfg),
        .entry  (entry_reg),
        .usable (usable)
    );

    bfr_best_track u_best (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .entry         (entry_reg),
        .usable        (usable),
        .m_ready       (m_ready),
        .out_free      (out_free),
        .m_valid       (m_valid),
        .m_found       (m_found),
        .m_chosen_base (m_chosen_base)
    );

endmodule

### design/bfr_checker.sv
// ----------------------------------------------------------------------------
// Best-fit region finder port checker
// Watches the top-level ports for result and reset behaviour.
// ----------------------------------------------------------------------------
module bfr_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          s_entry_last,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_found,
    input logic [bfr_pkg::ADDR_W-1:0]    m_chosen_base
);

    // A stalled result word holds its contents.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found) && $stable(m_chosen_base))
        else $error("result word changed while stalled");

    // No fitting region means a zero base.
    a_zero_when_absent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_chosen_base == '0)
        else $error("base not zero without a found region");

    // A fresh result word rises only after a last entry has been accepted.
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_entry_last, 2))
        else $error("result word without a last entry");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid straight after reset");

endmodule

bind best_fit_region_finder bfr_checker u_bfr_checker (.*);

### tb/sv/tb_best_fit_region_finder.sv
// ----------------------------------------------------------------------------
// Best-fit region finder testbench
// Drives memory-map entries into the finder under random idling and
// back-pressure, keeps its own running best-fit search, and checks every
// result word field by field against the expected result of its map.
// ----------------------------------------------------------------------------
module tb_best_fit_region_finder;

    import bfr_pkg::*;

    // Spare register indexes that the block must ignore when written.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;

    // A result word leaves through the input and output registers once its last
    // entry is taken, and a non-last entry is folded into the running best from
    // the input register, so this quiet spell is enough before touching registers.
    localparam int DRAIN_CYCLES = 4;

    // Longest correct quiet spell: the forced receiver hold-off (HOLD_CYCLES)
    // plus a long gap on either side. Several times that is allowed.
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 200;

    localparam logic [ADDR_W-1:0] ALL_ONES = '1;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] base;
    } map_result_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [ADDR_W-1:0]    cfg_wr_data   = '0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [ADDR_W-1:0]    s_entry_base  = '0;
    logic [ADDR_W-1:0]    s_entry_size  = '0;
    logic [KIND_W-1:0]    s_entry_kind  = '0;
    logic                 s_entry_last  = 1'b0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic                 m_found;
    logic [ADDR_W-1:0]    m_chosen_base;

    // Shadow of the configuration registers, updated as each write is issued.
    logic [ADDR_W-1:0]     want_size_q  = '0;
    logic [EXCL_CNT_W-1:0] excl_count_q = '0;
    logic [ADDR_W-1:0]     excl_lo_q [EXCL_REGS] = '{default: '0};
    logic [ADDR_W-1:0]     excl_hi_q [EXCL_REGS] = '{default: '0};

    // Running best of the map currently streaming in.
    logic [ADDR_W-1:0] best_size_q = '1;
    logic [ADDR_W-1:0] best_base_q = '0;
    logic              have_best_q = 1'b0;

    map_result_t pending_results[$];

    int  error_count   = 0;
    int  quiet_cycles  = 0;
    int  hold_request  = 0;
    bit  sender_steady = 1'b0;
    bit  sink_eager    = 1'b0;

    best_fit_region_finder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_entry_base  (s_entry_base),
        .s_entry_size  (s_entry_size),
        .s_entry_kind  (s_entry_kind),
        .s_entry_last  (s_entry_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_chosen_base (m_chosen_base)
    );

    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    // ------------------------------------------------------------------------
    // Search model
    // ------------------------------------------------------------------------

    // Half-open overlap with the entry end held in one extra bit, so that an
    // entry running past the top of the address space does not wrap round.
    function automatic bit overlaps_range(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] size,
                                          logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
        logic [ADDR_W:0] stop;
        stop = {1'b0, base} + {1'b0, size};
        return (base < hi) && ({1'b0, lo} < stop);
    endfunction

    // Folds one entry into the running best. On the last entry of a map it
    // hands back the result word that the map should produce and clears the
    // running best for the next map.
    function automatic void fold_entry(entry_t ent, output bit emits, output map_result_t res);
        int active;
        bit blocked;
        active = int'(excl_count_q);
        if (active > MAX_EXCLUSIONS) active = MAX_EXCLUSIONS;
        if (active > EXCL_REGS) active = EXCL_REGS;
        blocked = 1'b0;
        for (int i = 0; i < active; i++) begin
            if (overlaps_range(ent.base, ent.size, excl_lo_q[i], excl_hi_q[i])) blocked = 1'b1;
        end
        // A strict compare keeps the earlier of two equal sizes.
        if (!blocked && ent.kind == KIND_USABLE_RAM && ent.size >= want_size_q &&
            (!have_best_q || ent.size < best_size_q)) begin
            best_size_q = ent.size;
            best_base_q = ent.base;
            have_best_q = 1'b1;
        end
        emits = ent.last;
        res   = '0;
        if (ent.last) begin
            res.found   = have_best_q;
            res.base    = have_best_q ? best_base_q : '0;
            best_size_q = '1;
            best_base_q = '0;
            have_best_q = 1'b0;
        end
    endfunction

    // Every entry word taken by the block is folded into the model at the
    // same edge, so the expectation queue always mirrors what is in flight.
    always @(posedge aclk) begin : entry_monitor
        entry_t      ent;
        bit          emits;
        map_result_t res;
        if (aresetn && s_valid && s_ready) begin
            ent.base = s_entry_base;
            ent.size = s_entry_size;
            ent.kind = s_entry_kind;
            ent.last = s_entry_last;
            fold_entry(ent, emits, res);
            if (emits) pending_results.push_back(res);
        end
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
        $display("MISMATCH %s: got %h, expected %h", what, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin : result_checker
        map_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result word, base", m_chosen_base, '0);
            end else begin
                want = pending_results.pop_front();
                if (m_found !== want.found)
                    report_mismatch("found", ADDR_W'(m_found), ADDR_W'(want.found));
                if (m_chosen_base !== want.base)
                    report_mismatch("chosen_base", m_chosen_base, want.base);
            end
        end
    end

    // The run is abandoned if neither channel moves a word for too long.
    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Idling on both channels
    // ------------------------------------------------------------------------

    // Mostly back-to-back or short gaps, with the odd long one.
    function automatic int draw_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 2);
        if (roll < 97) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // The receiver stalls at random, or for a fixed long hold-off when one is
    // requested; the hold-off is counted here, not in the sending thread.
    initial begin : result_sink
        int stall;
        forever begin
            @(posedge aclk);
            stall = 0;
            if (hold_request > 0) begin
                stall        = hold_request;
                hold_request = 0;
            end else if (!sink_eager && $urandom_range(0, 3) == 0) begin
                stall = draw_gap();
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------------

    // Offers one entry word and returns at the edge where it is taken. Valid
    // is only lowered when a gap is wanted, so it never drops and rises again
    // within one step.
    task automatic send_entry(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] size,
                              logic [KIND_W-1:0] kind, logic last);
        int gap;
        gap = sender_steady ? 0 : draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_entry_base <= base;
        s_entry_size <= size;
        s_entry_kind <= kind;
        s_entry_last <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stops offering, waits for every outstanding result, then lets the
    // pipeline settle so that no entry is still being folded in.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        case (idx)
            REG_REQUEST_SIZE: want_size_q  = data;
            REG_EXCL_COUNT:   excl_count_q = data[EXCL_CNT_W-1:0];
            REG_EXCL0_START:  excl_lo_q[0] = data;
            REG_EXCL0_END:    excl_hi_q[0] = data;
            REG_EXCL1_START:  excl_lo_q[1] = data;
            REG_EXCL1_END:    excl_hi_q[1] = data;
            default: ;
        endcase
    endtask

    // Writes every register, then pokes one of the unused indexes with junk,
    // which must leave the configuration untouched. Called only when idle.
    task automatic set_config(logic [ADDR_W-1:0] req, logic [ADDR_W-1:0] count_word,
                              logic [ADDR_W-1:0] lo0, logic [ADDR_W-1:0] hi0,
                              logic [ADDR_W-1:0] lo1, logic [ADDR_W-1:0] hi1);
        write_cfg(REG_REQUEST_SIZE, req);
        write_cfg(REG_EXCL_COUNT, count_word);
        write_cfg(REG_EXCL0_START, lo0);
        write_cfg(REG_EXCL0_END, hi0);
        write_cfg(REG_EXCL1_START, lo1);
        write_cfg(REG_EXCL1_END, hi1);
        write_cfg($urandom_range(0, 1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
                  {$urandom(), $urandom()});
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [ADDR_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Narrow settings keep addresses within a few kilobytes so that entries
    // hit the exclusion ranges and each other often; wide settings spread
    // every field over its full width.
    task automatic random_config(bit wide);
        logic [ADDR_W-1:0] req;
        logic [ADDR_W-1:0] lo [EXCL_REGS];
        logic [ADDR_W-1:0] hi [EXCL_REGS];
        req = wide ? rand_word() >> $urandom_range(0, 63) : ADDR_W'($urandom_range(0, 512));
        for (int i = 0; i < EXCL_REGS; i++) begin
            if (wide) begin
                lo[i] = rand_word();
                hi[i] = $urandom_range(0, 2) != 0 ? lo[i] + (rand_word() >> $urandom_range(1, 63))
                                                   : rand_word();
            end else begin
                lo[i] = ADDR_W'($urandom_range(0, 4095));
                // Now and then an arbitrary end, which may well be inverted.
                hi[i] = $urandom_range(0, 9) < 7 ? lo[i] + ADDR_W'($urandom_range(1, 1024))
                                                  : ADDR_W'($urandom_range(0, 4095));
            end
        end
        // Junk above the count bits must be dropped by the block.
        set_config(req, (rand_word() << EXCL_CNT_W) | ADDR_W'($urandom_range(0, 3)),
                   lo[0], hi[0], lo[1], hi[1]);
    endtask

    // Sends whole maps of one to eight entries until at least the given
    // number of entries has gone in. Most entries are usable-type with sizes
    // near the request, so ties and close calls are common; about one in ten
    // is pure noise over the full field widths.
    task automatic send_random_maps(int entry_total, bit wide);
        int                sent;
        int                map_len;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] size;
        logic [KIND_W-1:0] kind;
        sent = 0;
        while (sent < entry_total) begin
            map_len = $urandom_range(1, 8);
            for (int i = 0; i < map_len; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    base = rand_word();
                    size = rand_word();
                    kind = $urandom();
                end else begin
                    if (wide) begin
                        base = $urandom_range(0, 3) == 0 ? ALL_ONES - ADDR_W'($urandom_range(0, 4095))
                                                         : rand_word();
                        size = $urandom_range(0, 1) ? want_size_q + ADDR_W'($urandom_range(0, 3) * 64)
                                                    : rand_word() >> $urandom_range(0, 63);
                    end else begin
                        base = ADDR_W'($urandom_range(0, 4095));
                        size = $urandom_range(0, 9) < 7 ? want_size_q + ADDR_W'($urandom_range(0, 15) * 32)
                                                        : ADDR_W'($urandom_range(0, 1023));
                    end
                    kind = $urandom_range(0, 19) < 17 ? KIND_USABLE_RAM : KIND_W'($urandom_range(0, 3));
                end
                send_entry(base, size, kind, i == map_len - 1);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Out of reset: no request size and no exclusions, so a zero-size entry
    // of usable type is a fit.
    task automatic test_reset_settings();
        send_entry('0, '0, KIND_USABLE_RAM, 1'b1);
        drain();
    endtask

    // Exclusion handling with a count of three, which acts as two; the second range
    // is inverted and blocks only the first entry, of wrong type. Covers wrong types,
    // entries too small, an entry straddling an exclusion end, one touching it,
    // and a tie that must keep the earlier entry. A second map has nothing usable.
    task automatic test_exclusions_and_ties();
        set_config(64'h100, 64'h3, 64'h1000, 64'h2000, 64'h5000, 64'h4000);
        send_entry(64'h0,    64'h1_0000, KIND_W'(2),      1'b0);
        send_entry(64'h6000, 64'hFF,     KIND_USABLE_RAM, 1'b0);
        send_entry(64'h1F00, 64'h200,    KIND_USABLE_RAM, 1'b0);
        send_entry(64'h2000, 64'h100,    KIND_USABLE_RAM, 1'b0);
        send_entry(64'h4800, 64'h1000,   KIND_USABLE_RAM, 1'b0);
        send_entry(64'h3000, 64'h100,    KIND_USABLE_RAM, 1'b0);
        send_entry(64'h0,    64'h0,      '1,              1'b1);
        send_entry(64'h1800, 64'h400,    KIND_USABLE_RAM, 1'b1);
        drain();
    endtask

    // Largest possible request: only all-ones sizes qualify, and their ends
    // run past the top of the address space without wrapping. The second
    // range is empty.
    task automatic test_top_of_space();
        set_config(ALL_ONES, 64'h2, 64'h100, 64'h200, 64'h50, 64'h50);
        send_entry(64'h1,   ALL_ONES, KIND_USABLE_RAM, 1'b0);
        send_entry(64'h200, ALL_ONES, KIND_USABLE_RAM, 1'b0);
        send_entry(64'h40,  64'h20,   KIND_USABLE_RAM, 1'b0);
        send_entry(64'h300, ALL_ONES, KIND_USABLE_RAM, 1'b1);
        send_entry(64'h0,   ALL_ONES - 1, KIND_USABLE_RAM, 1'b1);
        drain();
    endtask

    // One exclusion spanning nearly everything: zero-size entries at either
    // end of it overlap nothing, one inside it is blocked. Junk above the
    // count bits must be ignored.
    task automatic test_full_range_exclusion();
        set_config('0, ALL_ONES - 2, '0, ALL_ONES, ALL_ONES, '0);
        send_entry(64'h5,  '0, KIND_USABLE_RAM, 1'b0);
        send_entry(ALL_ONES, '0, KIND_USABLE_RAM, 1'b0);
        send_entry(64'h0,  '0, KIND_USABLE_RAM, 1'b1);
        drain();
    endtask

    // Random maps over several narrow settings; some phases run with no
    // idling at all on either side.
    task automatic test_random_narrow();
        for (int phase = 0; phase < 6; phase++) begin
            random_config(1'b0);
            sender_steady = ($urandom_range(0, 3) == 0);
            sink_eager    = ($urandom_range(0, 3) == 0);
            send_random_maps(70, 1'b0);
            drain();
        end
        sender_steady = 1'b0;
        sink_eager    = 1'b0;
    endtask

    task automatic test_random_wide();
        for (int phase = 0; phase < 2; phase++) begin
            random_config(1'b1);
            send_random_maps(70, 1'b1);
            drain();
        end
    endtask

    // The receiver holds off for a long stretch while short maps arrive back
    // to back, so result words pile up and the block must stall its input.
    task automatic test_backpressure_fill();
        random_config(1'b0);
        sender_steady = 1'b1;
        hold_request  = HOLD_CYCLES;
        send_random_maps(40, 1'b0);
        sender_steady = 1'b0;
        drain();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_settings();
        test_exclusions_and_ties();
        test_top_of_space();
        test_full_range_exclusion();
        test_random_narrow();
        test_random_wide();
        test_backpressure_fill();

        // drain() has already waited for the last result and let the block
        // settle, so any stray word would have been flagged by now.
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
